// ----- hw/rtl/m4rm_pkg.sv -----
// Shared types and constants for the 4x4 matrix row multiply core.
`timescale 1ns / 1ps
`default_nettype none

package m4rm_pkg;

    // Active matrix order and fixed-point fraction width.
    localparam int unsigned ORDER     = 4;
    localparam int unsigned FRAC_BITS = 16;

    // Physical storage dimension (row and column count of the datapath).
    localparam int unsigned DIM       = 4;
    localparam int unsigned ELEM_W    = 32;
    localparam int unsigned PROD_W    = 2 * ELEM_W;
    // Four full products summed without overflow.
    localparam int unsigned SUM_W     = PROD_W + 2;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_MUL  = 1'b1
    } op_t;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    typedef struct packed
    {
        op_t         op;
        logic [1:0]  row_index;
        elem_t       elem_0;
        elem_t       elem_1;
        elem_t       elem_2;
        elem_t       elem_3;
    } cmd_word_t;

    typedef struct packed
    {
        logic [1:0]  out_row;
        elem_t       prod_0;
        elem_t       prod_1;
        elem_t       prod_2;
        elem_t       prod_3;
    } res_word_t;

endpackage

`default_nettype wire

// ----- hw/rtl/matrix4_row_multiply_core.sv -----
// Top level of the 4x4 matrix row multiply core: load pipe, multiplier bank, reduce stage.
`timescale 1ns / 1ps
`default_nettype none

// 4x4 signed Q16.16 matrix row multiplier. The right-hand matrix is held in
// registers and written one row per load word (op OP_LOAD, no result word).
// A multiply word (op OP_MUL) carries one row of the left matrix and yields
// one result word: the row times each stored column, summed exactly, shifted
// right arithmetically by FRAC_BITS (floor) and saturated to 32 bits.
// Throughput is one word per clock while no stage is stalled. A multiply
// word passes through the input register, a bank of sixteen 32x32
// multipliers into a product register, then the four-term add, shift and
// saturate into the output register. A load word writes the matrix as it
// leaves the input register, so a multiply accepted on the very next clock
// already sees the new row. Words leave in the order they arrived.
// Each stage holds its word while the next stage is full and stalled; the
// output register lets a new word enter while a result still waits.

module matrix4_row_multiply_core
(
    input  wire                     clk,
    input  wire                     rst_n,

    input  wire                     cmd_valid,
    output logic                    cmd_stall,
    input  wire m4rm_pkg::cmd_word_t cmd,

    output logic                    res_valid,
    input  wire                     res_stall,
    output m4rm_pkg::res_word_t     res
);

    // Right-hand matrix, row-major.
    m4rm_pkg::elem_t     mat_reg [m4rm_pkg::DIM][m4rm_pkg::DIM];

    // Stage 1: accepted word.
    logic                s1_valid_reg;
    m4rm_pkg::cmd_word_t s1_word_reg;

    // Stage 2: raw products, indexed [column j][term k].
    logic                s2_valid_reg;
    logic [1:0]          s2_row_reg;
    m4rm_pkg::prod_t     s2_prod_reg [m4rm_pkg::DIM][m4rm_pkg::DIM];

    // Output register.
    logic                res_valid_reg;
    m4rm_pkg::res_word_t res_reg;

    m4rm_pkg::elem_t     left [m4rm_pkg::DIM];
    m4rm_pkg::prod_t     prod_next [m4rm_pkg::DIM][m4rm_pkg::DIM];
    m4rm_pkg::elem_t     col_res [m4rm_pkg::DIM];
    m4rm_pkg::res_word_t res_next;

    logic                out_ready;
    logic                s2_ready;
    logic                s2_move;
    logic                s1_move;
    logic                s1_is_load;
    logic                s1_is_mul;
    logic                cmd_take;

    // Handshake chain: a stage moves when the one after it can take a word.
    assign out_ready  = !res_valid_reg || !res_stall;
    assign s2_move    = s2_valid_reg && out_ready;
    assign s2_ready   = !s2_valid_reg || out_ready;
    assign s1_is_load = s1_valid_reg && (s1_word_reg.op == m4rm_pkg::OP_LOAD);
    assign s1_is_mul  = s1_valid_reg && (s1_word_reg.op == m4rm_pkg::OP_MUL);
    // A load word retires from stage 1 on its own; a multiply needs stage 2.
    assign s1_move    = s1_is_load || (s1_is_mul && s2_ready);
    assign cmd_stall  = s1_valid_reg && !s1_move;
    assign cmd_take   = cmd_valid && !cmd_stall;

    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    // Left row from stage 1; unused columns contribute nothing.
    always_comb
    begin
        left[0] = s1_word_reg.elem_0;
        left[1] = s1_word_reg.elem_1;
        left[2] = s1_word_reg.elem_2;
        left[3] = s1_word_reg.elem_3;
    end

    // Multiplier bank: one signed 32x32 product per matrix element.
    always_comb
    begin
        for (int j = 0; j < m4rm_pkg::DIM; j++)
        begin
            for (int k = 0; k < m4rm_pkg::DIM; k++)
            begin
                prod_next[j][k] = m4rm_pkg::PROD_W'(left[k])
                                * m4rm_pkg::PROD_W'(mat_reg[k][j]);
            end
        end
    end

    // Reduce: exact sum, floor shift, saturate.
    always_comb
    begin
        m4rm_pkg::sum_t acc;
        m4rm_pkg::sum_t shifted;
        for (int j = 0; j < m4rm_pkg::DIM; j++)
        begin
            acc = '0;
            for (int k = 0; k < m4rm_pkg::DIM; k++)
            begin
                if (k < m4rm_pkg::ORDER)
                begin
                    acc = acc + m4rm_pkg::SUM_W'(s2_prod_reg[j][k]);
                end
            end
            shifted = acc >>> m4rm_pkg::FRAC_BITS;
            if (j >= m4rm_pkg::ORDER)
            begin
                col_res[j] = '0;
            end
            else if (shifted > m4rm_pkg::SUM_W'(signed'(32'sh7FFF_FFFF)))
            begin
                col_res[j] = 32'sh7FFF_FFFF;
            end
            else if (shifted < m4rm_pkg::SUM_W'(signed'(32'sh8000_0000)))
            begin
                col_res[j] = 32'sh8000_0000;
            end
            else
            begin
                col_res[j] = shifted[m4rm_pkg::ELEM_W-1:0];
            end
        end
        res_next.out_row = s2_row_reg;
        res_next.prod_0  = col_res[0];
        res_next.prod_1  = col_res[1];
        res_next.prod_2  = col_res[2];
        res_next.prod_3  = col_res[3];
    end

    // Valid bits and the stored matrix.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int r = 0; r < m4rm_pkg::DIM; r++)
            begin
                for (int c = 0; c < m4rm_pkg::DIM; c++)
                begin
                    mat_reg[r][c] <= '0;
                end
            end
        end
        else
        begin
            if (cmd_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_is_mul && s2_ready)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_move)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (s2_move)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end

            // Row write as the load word retires; rows past ORDER are dropped.
            if (s1_is_load && (32'(s1_word_reg.row_index) < m4rm_pkg::ORDER))
            begin
                for (int c = 0; c < m4rm_pkg::DIM; c++)
                begin
                    if (c < m4rm_pkg::ORDER)
                    begin
                        mat_reg[s1_word_reg.row_index][c] <= left[c];
                    end
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            s1_word_reg <= cmd;
        end
        if (s1_is_mul && s2_ready)
        begin
            s2_row_reg  <= s1_word_reg.row_index;
            s2_prod_reg <= prod_next;
        end
        if (s2_move)
        begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for matrix4_row_multiply_core: directed and random row words.
`timescale 1ns / 1ps

module tb;

    // A long receiver hold must stay well under the no-progress limit.
    localparam int unsigned IDLE_LIMIT  = 2000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned MUL_PCT     = 70;

    localparam m4rm_pkg::elem_t Q_ONE  = 32'sh0001_0000;
    localparam m4rm_pkg::elem_t E_MAX  = 32'sh7fff_ffff;
    localparam m4rm_pkg::elem_t E_MIN  = 32'sh8000_0000;
    localparam m4rm_pkg::elem_t E_P1   = 32'sh0000_0001;
    localparam m4rm_pkg::elem_t E_N1   = 32'shffff_ffff;
    localparam m4rm_pkg::elem_t E_P3   = 32'sh0000_0003;
    localparam m4rm_pkg::sum_t  SAT_HI = (m4rm_pkg::sum_t'(1) <<< 31) - 1;
    localparam m4rm_pkg::sum_t  SAT_LO = -(m4rm_pkg::sum_t'(1) <<< 31);

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cmd_valid = 1'b0;
    logic                 cmd_stall;
    m4rm_pkg::cmd_word_t  cmd       = '0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    m4rm_pkg::res_word_t  res;

    // Shadow copy of the right-hand matrix, row-major.
    m4rm_pkg::elem_t      coef [m4rm_pkg::DIM][m4rm_pkg::DIM] = '{default: '0};
    m4rm_pkg::res_word_t  expected_rows [$];

    int unsigned mismatches    = 0;
    int unsigned idle_cycles   = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    logic        hold_rx       = 1'b0;

    matrix4_row_multiply_core i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic m4rm_pkg::elem_t elem_of(m4rm_pkg::cmd_word_t w, int k);
        case (k)
            0:       return w.elem_0;
            1:       return w.elem_1;
            2:       return w.elem_2;
            default: return w.elem_3;
        endcase
    endfunction

    // Load word: rows past the active order and columns past it are dropped.
    function automatic void load_row(m4rm_pkg::cmd_word_t w);
        if (w.row_index < m4rm_pkg::ORDER)
        begin
            for (int k = 0; k < m4rm_pkg::DIM && k < m4rm_pkg::ORDER; k++)
                coef[w.row_index][k] = elem_of(w, k);
        end
    endfunction

    // Multiply word: exact 66-bit dot product per column, floor shift by
    // FRAC_BITS, clamp to 32 bits. Columns past the order read as zero.
    function automatic m4rm_pkg::res_word_t product_row(m4rm_pkg::cmd_word_t w);
        m4rm_pkg::elem_t     col [m4rm_pkg::DIM];
        m4rm_pkg::sum_t      acc;
        m4rm_pkg::sum_t      a;
        m4rm_pkg::sum_t      b;
        m4rm_pkg::res_word_t r;
        for (int j = 0; j < m4rm_pkg::DIM; j++)
        begin
            col[j] = '0;
            if (j < m4rm_pkg::ORDER)
            begin
                acc = '0;
                for (int k = 0; k < m4rm_pkg::DIM && k < m4rm_pkg::ORDER; k++)
                begin
                    a   = elem_of(w, k);
                    b   = coef[k][j];
                    acc = acc + a * b;
                end
                acc = acc >>> m4rm_pkg::FRAC_BITS;
                if (acc > SAT_HI)
                    col[j] = E_MAX;
                else if (acc < SAT_LO)
                    col[j] = E_MIN;
                else
                    col[j] = m4rm_pkg::elem_t'(acc);
            end
        end
        r.out_row = w.row_index;
        r.prod_0  = col[0];
        r.prod_1  = col[1];
        r.prod_2  = col[2];
        r.prod_3  = col[3];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking and prediction, both sampled at the rising edge
    // ------------------------------------------------------------------

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s expected %h got %h", $realtime, what, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        m4rm_pkg::res_word_t want;
        // Check first: a result leaving can never belong to a word entering now.
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_rows.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result word with none expected: %p", $realtime, res);
            end
            else
            begin
                want = expected_rows.pop_front();
                check_field("out_row", 32'(want.out_row), 32'(res.out_row));
                check_field("prod_0", want.prod_0, res.prod_0);
                check_field("prod_1", want.prod_1, res.prod_1);
                check_field("prod_2", want.prod_2, res.prod_2);
                check_field("prod_3", want.prod_3, res.prod_3);
            end
        end
        // Words are handled in arrival order, so a load updates the shadow
        // matrix right away and the next multiply sees it.
        if (rst_n && cmd_valid && !cmd_stall)
        begin
            if (cmd.op == m4rm_pkg::OP_MUL)
                expected_rows.push_back(product_row(cmd));
            else
                load_row(cmd);
        end
    end

    // No-progress watchdog: any accepted word on either side resets it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("matrix4_row_multiply_core: mismatch");
                $finish;
            end
        end
    end

    // Receiver: random stall, or solid stall while a long hold runs.
    always @(posedge clk)
        res_stall <= hold_rx || ($urandom_range(99) < stall_pct);

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Offer one word, with a random idle gap first, and wait until taken.
    task automatic send_word(m4rm_pkg::cmd_word_t w);
        if ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        cmd       <= w;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (cmd_stall);
    endtask

    function automatic m4rm_pkg::cmd_word_t make_word(m4rm_pkg::op_t op, logic [1:0] row,
                                                      m4rm_pkg::elem_t e0, m4rm_pkg::elem_t e1,
                                                      m4rm_pkg::elem_t e2, m4rm_pkg::elem_t e3);
        m4rm_pkg::cmd_word_t w;
        w.op        = op;
        w.row_index = row;
        w.elem_0    = e0;
        w.elem_1    = e1;
        w.elem_2    = e2;
        w.elem_3    = e3;
        return w;
    endfunction

    // Mix of full-range values (mostly saturating products), scaled values
    // that keep sums in range, and the corner values.
    function automatic m4rm_pkg::elem_t rand_elem();
        m4rm_pkg::elem_t v;
        int unsigned     pick;
        v    = $urandom;
        pick = $urandom_range(99);
        if (pick < 30)
            return v;
        if (pick < 85)
            return v >>> $urandom_range(30, 8);
        case ($urandom_range(6))
            0:       return '0;
            1:       return E_P1;
            2:       return E_N1;
            3:       return Q_ONE;
            4:       return -Q_ONE;
            5:       return E_MAX;
            default: return E_MIN;
        endcase
    endfunction

    function automatic m4rm_pkg::cmd_word_t rand_word(int unsigned mul_pct);
        return make_word(($urandom_range(99) < mul_pct) ? m4rm_pkg::OP_MUL : m4rm_pkg::OP_LOAD,
                         2'($urandom_range(3)),
                         rand_elem(), rand_elem(), rand_elem(), rand_elem());
    endfunction

    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct     = 0;
        // identity matrix: a multiply passes the left row through
        for (int r = 0; r < m4rm_pkg::DIM; r++)
            send_word(make_word(m4rm_pkg::OP_LOAD, 2'(r),
                                (r == 0) ? Q_ONE : '0, (r == 1) ? Q_ONE : '0,
                                (r == 2) ? Q_ONE : '0, (r == 3) ? Q_ONE : '0));
        send_word(make_word(m4rm_pkg::OP_MUL, 2'd0, E_MAX, E_MIN, E_P1, E_N1));
        // all-max matrix: saturate high, then low
        for (int r = 0; r < m4rm_pkg::DIM; r++)
            send_word(make_word(m4rm_pkg::OP_LOAD, 2'(r), E_MAX, E_MAX, E_MAX, E_MAX));
        send_word(make_word(m4rm_pkg::OP_MUL, 2'd1, E_MAX, E_MAX, E_MAX, E_MAX));
        send_word(make_word(m4rm_pkg::OP_MUL, 2'd2, E_MIN, E_MIN, E_MIN, E_MIN));
        // all-min matrix: min times min is the largest positive sum
        for (int r = 0; r < m4rm_pkg::DIM; r++)
            send_word(make_word(m4rm_pkg::OP_LOAD, 2'(r), E_MIN, E_MIN, E_MIN, E_MIN));
        send_word(make_word(m4rm_pkg::OP_MUL, 2'd3, E_MIN, E_MIN, E_MIN, E_MIN));
        send_word(make_word(m4rm_pkg::OP_MUL, 2'd0, '0, '0, '0, '0));
        // negative sub-LSB products must floor toward minus infinity
        send_word(make_word(m4rm_pkg::OP_LOAD, 2'd0, E_P1, E_N1, E_P3, E_MAX));
        send_word(make_word(m4rm_pkg::OP_MUL, 2'd1, E_N1, '0, '0, '0));
    endtask

    task automatic test_random(int unsigned count, int unsigned tx_idle, int unsigned rx_stall);
        send_idle_pct = tx_idle;
        stall_pct     = rx_stall;
        for (int unsigned n = 0; n < count; n++)
            send_word(rand_word(MUL_PCT));
    endtask

    // Receiver holds off for a long stretch while multiplies keep coming,
    // so the pipe fills and pushes stall back to the command side.
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        fork
            begin
                hold_rx <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rx <= 1'b0;
            end
            begin
                for (int n = 0; n < 60; n++)
                    send_word(rand_word(100));
            end
        join
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(500, 0, 0);
        test_random(500, 49, 0);
        test_backpressure();
        test_random(500, 0, 49);
        test_random(500, 38, 38);

        // drain: the watchdog catches results that never arrive
        cmd_valid <= 1'b0;
        while (expected_rows.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("matrix4_row_multiply_core: match");
        else
            $display("matrix4_row_multiply_core: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/m4rm_pkg.sv
hw/rtl/matrix4_row_multiply_core.sv
sim/tb.sv
